/* rtl/active_flow_table_filter_defines.svh */
// ----------------------------------------------------------------------------
// Active flow table filter assertion macros
// Shared helpers for concurrent checks, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ACTIVE_FLOW_TABLE_FILTER_DEFINES_SVH
`define ACTIVE_FLOW_TABLE_FILTER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define AFTF_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define AFTF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/aftf_pkg.sv */
// ----------------------------------------------------------------------------
// Active flow table filter package
// Item types shared by the front queue and engine; result type of the engine.
// ----------------------------------------------------------------------------
package aftf_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 16;
  localparam int unsigned StampW = 32;
  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned OutUserW = 2;

  // Packed so that the lowest bits hold the source address, as on the bus.
  typedef struct packed {
    logic [PortW-1:0] dst_port;
    logic [PortW-1:0] from_port;
    logic [AddrW-1:0] dst_addr;
    logic [AddrW-1:0] from_addr;
  } tuple_t;

  typedef struct packed {
    logic [StampW-1:0] now;
    logic              proto;
    tuple_t            tuple;
  } item_t;

  typedef struct packed {
    logic accept;
    logic created;
    logic full;
  } result_t;

endpackage

/* rtl/aftf_front.sv */
// ----------------------------------------------------------------------------
// Active flow table filter front queue
// Accept header transfers, unpack them and hold up to two for the engine.
// ----------------------------------------------------------------------------
module aftf_front
  import aftf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [0:0]          s_axis_tuser,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output item_t               item_o
);

  localparam logic [1:0] Depth = 2'd2;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;
  item_t      in_item;

  always_comb begin
    in_item.tuple = tuple_t'(s_axis_tdata[95:0]);
    in_item.now   = s_axis_tdata[127:96];
    in_item.proto = s_axis_tuser[0];
  end

  assign s_axis_tready = (fill_q != Depth);
  assign item_valid_o  = (fill_q != 2'd0);
  assign item_o        = slot_q[rd_ptr_q];

  assign push = s_axis_tvalid && s_axis_tready;
  assign pop  = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

/* rtl/aftf_back.sv */
// ----------------------------------------------------------------------------
// Active flow table filter engine
// Scan the flow memory for the tuple, then insert or refresh and give a verdict.
// ----------------------------------------------------------------------------
module aftf_back
  import aftf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    mode_i,
  input  logic    item_valid_i,
  output logic    item_ready_o,
  input  item_t   item_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_ENTRIES);

  typedef struct packed {
    logic   en;
    tuple_t tuple;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  // Entries are never freed here, so slots below the fill count are the valid ones.
  entry_t               entry_mem [TABLE_ENTRIES];
  logic [TIME_BITS-1:0] stamp_mem [TABLE_ENTRIES];
  entry_t               rd_q;

  state_e          state_q, state_d;
  item_t           cur_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            hit_q, hit_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  result_t         res_q, res_d;
  logic            res_valid_q, res_valid_d;

  logic            match, last, out_free, full, en_old, en_new, wr_en, load;
  logic [IdxW-1:0] slot;
  result_t         verdict;

  assign item_ready_o = (state_q == ST_IDLE);
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  assign match    = (rd_q.tuple == cur_q.tuple);
  assign last     = ((CntW'(idx_q) + CntW'(1)) == cnt_q);
  assign out_free = !res_valid_q || res_ready_i;
  assign full     = !hit_q && (cnt_q == CntFull);
  assign slot     = hit_q ? idx_q : cnt_q[IdxW-1:0];
  assign en_old   = hit_q ? rd_q.en : cur_q.proto;
  assign en_new   = en_old | (mode_i & cur_q.proto);
  assign load     = (state_q == ST_DONE) && out_free;
  assign wr_en    = load && !full;

  always_comb begin
    verdict.full    = full;
    verdict.created = !hit_q && !full;
    // Drop a plain packet from an enabled sender, only in multicast mode.
    verdict.accept  = full || !mode_i || cur_q.proto || !en_new;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          idx_d   = '0;
          hit_d   = 1'b0;
          state_d = (cnt_q == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (match) begin
          hit_d   = 1'b1;
          state_d = ST_DONE;
        end else if (last) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = ST_READ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_d       = verdict;
          res_valid_d = 1'b1;
          cnt_d       = cnt_q + CntW'(verdict.created);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (item_valid_i && (state_q == ST_IDLE)) begin
      cur_q <= item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[slot] <= '{en: en_new, tuple: cur_q.tuple};
      stamp_mem[slot] <= TIME_BITS'(cur_q.now);
    end
    if (state_q == ST_READ) begin
      rd_q <= entry_mem[idx_q];
    end
  end

endmodule

/* rtl/active_flow_table_filter.sv */
// ----------------------------------------------------------------------------
// Active flow table filter
// Track active UDP senders and give an accept or drop verdict per packet.
// ----------------------------------------------------------------------------
// Input channel s_axis carries one packet header per transfer: tdata holds the
// four-tuple and the current time, tuser flags a redundancy-protocol packet.
// Output channel m_axis returns one verdict per header, in order: tdata[0] is
// accept, tuser marks a newly created entry or a full table.
// cfg_we_i/cfg_wdata_i write the multicast mode bit; write it only while idle.
// A two-deep queue takes headers while the engine works or the output stalls.
// The engine walks the flow memory one slot per compare, through a single
// read port with registered data: a header stops at the slot that holds its
// tuple, a miss walks all F entries in the table. Each header is registered
// in the queue before the engine takes it.
// The engine takes the next header in the cycle after it loads a verdict.
// When m_axis_tready is low the verdict holds in its register, the engine
// finishes the next header and waits, and the queue fills and drops tready.
// Reset empties the table (fill count to zero) and sets multicast mode; there
// is no clearing pass, the block accepts headers straight out of reset.
// ----------------------------------------------------------------------------
`include "active_flow_table_filter_defines.svh"

module active_flow_table_filter
  import aftf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // source_address, destination_address, source_port, destination_port, now
  input  logic [InDataW-1:0]  s_axis_tdata,
  // from_protocol_path
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // accept, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // entry_created, table_full
  output logic [OutUserW-1:0] m_axis_tuser
);

  logic    mode_q;
  logic    item_valid, item_ready;
  item_t   item;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  aftf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  aftf_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TIME_BITS     (TIME_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {{(OutDataW-1){1'b0}}, res.accept};
  assign m_axis_tuser = {res.full, res.created};

  `AFTF_ASSERT(a_created_xor_full, !(m_axis_tvalid && res.created && res.full), "created and full")
  `AFTF_ASSERT_IMP(a_full_accepts, m_axis_tvalid && res.full, res.accept, "full table must accept")
  `AFTF_ASSERT_IMP(a_drop_needs_mode, m_axis_tvalid && !res.accept, mode_q, "drop with mode off")

endmodule

/* test/active_flow_table_filter_tb.sv */
// ----------------------------------------------------------------------------
// Active flow table filter testbench
// Feeds packet headers through the input stream and checks each verdict
// against an in-bench flow table predictor or a typed-in probe verdict.
// A short probe table walks both filter modes first. Random headers follow,
// mostly from a sender pool, so flows are created, refreshed, enabled and
// dropped, and the table runs full. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module active_flow_table_filter_tb;
  import aftf_pkg::*;

  localparam int unsigned FLOW_SLOTS    = 64;
  localparam int unsigned POOL_SIZE     = 80;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned PROBE_ROWS    = 14;

  localparam logic MODE_OFF       = 1'b0;
  localparam logic MODE_MULTICAST = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [AddrW-1:0]  from_addr;
    logic [AddrW-1:0]  dst_addr;
    logic [PortW-1:0]  from_port;
    logic [PortW-1:0]  dst_port;
    logic              proto;
    logic [StampW-1:0] stamp;
    logic              typed;
    logic              accept;
    logic              created;
    logic              full;
  } probe_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_wdata_i   = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  // Flow table as the block should hold it.
  logic              flow_valid     [FLOW_SLOTS];
  tuple_t            flow_tuple     [FLOW_SLOTS];
  logic              flow_enabled   [FLOW_SLOTS];
  logic [StampW-1:0] flow_last_seen [FLOW_SLOTS];
  logic              filter_mode = MODE_MULTICAST;

  result_t verdict_q [$];
  tuple_t  sender_pool [POOL_SIZE];

  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;

  int unsigned mismatches   = 0;
  int unsigned headers_sent = 0;
  int unsigned new_flows    = 0;
  int unsigned drops        = 0;
  int unsigned full_hits    = 0;
  int unsigned mode_writes  = 0;

  // Expected verdicts are typed in where they follow directly from the rules.
  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{MODE_MULTICAST, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 32'h0,
      1'b1, 1'b1, 1'b1, 1'b0},
    '{MODE_MULTICAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF,
      1'b1, 1'b1, 1'b1, 1'b0},
    '{MODE_MULTICAST, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 32'h0000_0010,
      1'b1, 1'b1, 1'b0, 1'b0},
    '{MODE_MULTICAST, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 32'h0000_0011,
      1'b1, 1'b0, 1'b0, 1'b0},
    '{MODE_MULTICAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'h0,
      1'b1, 1'b0, 1'b0, 1'b0},
    '{MODE_MULTICAST, 32'h1, 32'h0, 16'h0, 16'h0, 1'b0, 32'h0000_0100,
      1'b1, 1'b1, 1'b1, 1'b0},
    '{MODE_MULTICAST, 32'h0, 32'h0, 16'h0, 16'h1, 1'b0, 32'h0000_0101,
      1'b1, 1'b1, 1'b1, 1'b0},
    '{MODE_MULTICAST, 32'h1, 32'h0, 16'h0, 16'h0, 1'b0, 32'h8000_0000,
      1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_OFF, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 32'h7FFF_FFFF,
      1'b1, 1'b1, 1'b0, 1'b0},
    '{MODE_OFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFE,
      1'b1, 1'b1, 1'b0, 1'b0},
    '{MODE_OFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 1'b1, 32'h1,
      1'b1, 1'b1, 1'b1, 1'b0},
    '{MODE_OFF, 32'h1, 32'h0, 16'h0, 16'h0, 1'b1, 32'h2,
      1'b1, 1'b1, 1'b0, 1'b0},
    // a protocol hit with the mode off must not have enabled the sender
    '{MODE_MULTICAST, 32'h1, 32'h0, 16'h0, 16'h0, 1'b0, 32'h3,
      1'b1, 1'b1, 1'b0, 1'b0},
    '{MODE_MULTICAST, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 1'b0, 32'h4,
      1'b1, 1'b0, 1'b0, 1'b0}
  };

  active_flow_table_filter #(
    .TABLE_ENTRIES(FLOW_SLOTS),
    .TIME_BITS    (StampW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Look the tuple up, insert on a miss, and work out the verdict.
  function automatic result_t predict_verdict(input item_t hdr);
    int      slot;
    result_t verdict;
    slot    = -1;
    verdict = '{accept: 1'b1, created: 1'b0, full: 1'b0};
    for (int i = 0; i < FLOW_SLOTS; i++) begin
      if (slot < 0 && flow_valid[i] && flow_tuple[i] == hdr.tuple) slot = i;
    end
    if (slot < 0) begin
      for (int i = 0; i < FLOW_SLOTS; i++) begin
        if (slot < 0 && !flow_valid[i]) slot = i;
      end
      if (slot < 0) begin
        verdict.full = 1'b1;
      end else begin
        flow_valid[slot]   = 1'b1;
        flow_tuple[slot]   = hdr.tuple;
        flow_enabled[slot] = hdr.proto;
        verdict.created    = 1'b1;
      end
    end
    if (slot >= 0) begin
      flow_last_seen[slot] = hdr.now;
      if (filter_mode == MODE_MULTICAST) begin
        if (hdr.proto) flow_enabled[slot] = 1'b1;
        verdict.accept = hdr.proto || !flow_enabled[slot];
      end
    end
    return verdict;
  endfunction

  // Mostly random, sometimes all zeros or all ones.
  function automatic logic [31:0] pick_field(input int unsigned width);
    logic [31:0] mask;
    mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return mask;
      default: return $urandom() & mask;
    endcase
  endfunction

  function automatic tuple_t fresh_tuple();
    tuple_t t;
    t.from_addr = AddrW'(pick_field(AddrW));
    t.dst_addr  = AddrW'(pick_field(AddrW));
    t.from_port = PortW'(pick_field(PortW));
    t.dst_port  = PortW'(pick_field(PortW));
    return t;
  endfunction

  task automatic push_header(input item_t hdr, input bit use_typed,
                             input result_t typed_verdict);
    int      gap;
    result_t predicted;
    gap = src_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hdr.now, hdr.tuple};
    s_axis_tuser  <= hdr.proto;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_verdict(hdr);
    verdict_q.push_back(use_typed ? typed_verdict : predicted);
    headers_sent++;
  endtask

  // Hold the input until every verdict is back and the engine is quiet.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic mode);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    filter_mode = mode;
    mode_writes++;
  endtask

  // Output side: stall a random number of cycles before each transfer.
  initial begin
    int stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{accept: m_axis_tdata[0], created: m_axis_tuser[0], full: m_axis_tuser[1]};
      if (got.created) new_flows++;
      if (!got.accept) drops++;
      if (got.full) full_hits++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("verdict with none pending: accept=%0b created=%0b full=%0b",
                   got.accept, got.created, got.full);
      end else begin
        want = verdict_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("verdict mismatch: expected a/c/f=%0b%0b%0b, got a/c/f=%0b%0b%0b",
                     want.accept, want.created, want.full,
                     got.accept, got.created, got.full);
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    item_t   hdr;
    result_t typed_verdict;
    tuple_t  t;
    int unsigned span;

    for (int i = 0; i < FLOW_SLOTS; i++) begin
      flow_valid[i]     = 1'b0;
      flow_tuple[i]     = '0;
      flow_enabled[i]   = 1'b0;
      flow_last_seen[i] = '0;
    end

    // Some senders differ from their neighbor in a single bit of one field.
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i > 0 && $urandom_range(0, 2) == 0) begin
        t = sender_pool[i-1];
        case ($urandom_range(0, 3))
          0: t.from_addr ^= 32'd1 << $urandom_range(0, AddrW - 1);
          1: t.dst_addr ^= 32'd1 << $urandom_range(0, AddrW - 1);
          2: t.from_port ^= 16'd1 << $urandom_range(0, PortW - 1);
          default: t.dst_port ^= 16'd1 << $urandom_range(0, PortW - 1);
        endcase
        sender_pool[i] = t;
      end else begin
        sender_pool[i] = fresh_tuple();
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_rows[r]) begin
      if (probe_rows[r].mode != filter_mode) set_mode(probe_rows[r].mode);
      hdr.tuple.from_addr = probe_rows[r].from_addr;
      hdr.tuple.dst_addr  = probe_rows[r].dst_addr;
      hdr.tuple.from_port = probe_rows[r].from_port;
      hdr.tuple.dst_port  = probe_rows[r].dst_port;
      hdr.proto           = probe_rows[r].proto;
      hdr.now             = probe_rows[r].stamp;
      typed_verdict = '{accept: probe_rows[r].accept, created: probe_rows[r].created,
                        full: probe_rows[r].full};
      push_header(hdr, probe_rows[r].typed, typed_verdict);
    end

    // Widen the pool up to all senders so the table fills gradually, then overflows.
    for (int p = 0; p < PHASES; p++) begin
      set_mode(p[0] ? MODE_MULTICAST : MODE_OFF);
      src_steady  = (p == 2);
      sink_steady = (p == 2 || p == 4);
      span = (24 * (p + 1) < POOL_SIZE) ? 24 * (p + 1) : POOL_SIZE;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 8) hdr.tuple = fresh_tuple();
        else hdr.tuple = sender_pool[$urandom_range(0, span - 1)];
        hdr.proto = ($urandom_range(0, 9) < 3);
        hdr.now   = $urandom();
        push_header(hdr, 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d headers in both filter modes (%0d mode writes)",
             headers_sent, mode_writes);
    $display("verdicts seen: %0d new flows, %0d drops, %0d table-full, %0d mismatches",
             new_flows, drops, full_hits, mismatches);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
